FILE: hdl/mlpt_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// MAC learning port table - shared definitions
// Field widths, event codes, table entry layout and reset constants.
// ---------------------------------------------------------------------------
package mlpt_pkg;

   localparam int SW_W   = 3;
   localparam int MAC_W  = 48;
   localparam int PORT_W = 32;
   localparam int PRIO_W = 32;

   localparam int DEF_TABLE_ENTRIES = 64;
   localparam int DEF_NUM_SWITCHES  = 8;

   // event kinds carried on the request tuser
   localparam logic [1:0] FUNC_MISS    = 2'd0;
   localparam logic [1:0] FUNC_REMOVE  = 2'd1;
   localparam logic [1:0] FUNC_CONNECT = 2'd2;

   localparam logic [MAC_W-1:0]  MAC_BCAST  = {MAC_W{1'b1}};
   localparam logic [PRIO_W-1:0] PRIO_RESET = PRIO_W'(100);

   localparam int REQ_DATA_W = 136;
   localparam int RSP_DATA_W = 72;

   // one learned entry as stored in the table memory
   typedef struct packed {
      logic              valid;
      logic [SW_W-1:0]   sw;
      logic [MAC_W-1:0]  mac;
      logic [PORT_W-1:0] port;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

FILE: hdl/mlpt_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// MAC learning port table - generic RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module mlpt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write and read, read data registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: hdl/mac_learning_port_table.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// MAC learning port table
// Per-switch MAC-to-port learning over one shared table of entries, with
// connect, packet-miss lookup/learn and flow-removed delete events.
// ---------------------------------------------------------------------------
//  channel | dir | tdata fields (lsb first)                         | tuser
//  req     | in  | switch_index, miss_reason_no_match, ingress_port, | func
//          |     | source_mac, target_mac                            |
//  rsp     | out | forward_valid, flood, out_port, learned,          | -
//          |     | flow_priority, table_full, no_table               |
//
// A no-match packet miss or a flow removal on a connected switch scans the
// table memory one entry per cycle through its single read port. Other events
// need no scan and go straight from accept to the result step.
// After reset a clearing pass writes every entry invalid, with req_tready low.
// One event is processed at a time; the next beat is taken while a finished
// result still waits on the rsp side.
// ---------------------------------------------------------------------------
module mac_learning_port_table #(
   parameter int TABLE_ENTRIES = mlpt_pkg::DEF_TABLE_ENTRIES,
   parameter int NUM_SWITCHES  = mlpt_pkg::DEF_NUM_SWITCHES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [2:0] switch_index, [3] miss_reason_no_match, [35:4] ingress_port,
   // [83:36] source_mac, [131:84] target_mac, [135:132] zero
   input  logic [mlpt_pkg::REQ_DATA_W-1:0] req_tdata,
   // [1:0] func
   input  logic [1:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [0] forward_valid, [1] flood, [33:2] out_port, [34] learned,
   // [66:35] flow_priority, [67] table_full, [68] no_table, [71:69] zero
   output logic [mlpt_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   import mlpt_pkg::*;

   localparam int IDX_W     = $clog2(TABLE_ENTRIES);
   localparam int CNT_W     = $clog2(TABLE_ENTRIES + 1);
   localparam int PRESENT_W = (NUM_SWITCHES < (1 << SW_W)) ? NUM_SWITCHES : (1 << SW_W);
   localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(TABLE_ENTRIES);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_ENTRIES - 1);

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_SCAN, ST_WRITE, ST_DONE
   } state_type;

   // request fields
   logic [SW_W-1:0]   req_sw;
   logic              req_no_match;
   logic [PORT_W-1:0] req_port;
   logic [MAC_W-1:0]  req_src;
   logic [MAC_W-1:0]  req_dst;

   assign req_sw       = req_tdata[2:0];
   assign req_no_match = req_tdata[3];
   assign req_port     = req_tdata[35:4];
   assign req_src      = req_tdata[83:36];
   assign req_dst      = req_tdata[131:84];

   state_type state_ff, state_in;
   logic [CNT_W-1:0]   issue_ff, issue_in;
   logic               chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]   chk_addr_ff, chk_addr_in;
   logic [1:0]         func_ff, func_in;
   logic [SW_W-1:0]    sw_ff, sw_in;
   logic [MAC_W-1:0]   src_ff, src_in;
   logic [MAC_W-1:0]   dst_ff, dst_in;
   logic [PORT_W-1:0]  port_ff, port_in;
   logic               dst_found_ff, dst_found_in;
   logic [IDX_W-1:0]   dst_idx_ff, dst_idx_in;
   logic               src_found_ff, src_found_in;
   logic               free_found_ff, free_found_in;
   logic [IDX_W-1:0]   free_idx_ff, free_idx_in;
   logic               res_fwd_ff, res_fwd_in;
   logic               res_flood_ff, res_flood_in;
   logic [PORT_W-1:0]  res_port_ff, res_port_in;
   logic               res_learned_ff, res_learned_in;
   logic [PRIO_W-1:0]  res_prio_ff, res_prio_in;
   logic               res_full_ff, res_full_in;
   logic               res_notab_ff, res_notab_in;
   logic [PRIO_W-1:0]  prio_ff, prio_in;
   logic [PRESENT_W-1:0] present_ff, present_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // table memory ports
   logic              ram_we;
   logic [IDX_W-1:0]  ram_waddr;
   entry_type         ram_wdata;
   entry_type         ram_rdata;
   logic [ENTRY_W-1:0] ram_rdata_raw;

   logic sw_slot_hit;
   logic sw_present;
   logic accept;
   logic scan_done;
   logic dst_en;
   logic ent_ok;
   logic do_learn;

   mlpt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (issue_ff[IDX_W-1:0]),
      .rd_data (ram_rdata_raw)
   );

   assign ram_rdata = entry_type'(ram_rdata_raw);

   // look up the connect flag of the requested switch
   always_comb begin
      sw_slot_hit = 1'b0;
      sw_present  = 1'b0;
      for (int i = 0; i < PRESENT_W; i++) begin
         if (req_sw == SW_W'(i)) begin
            sw_slot_hit = 1'b1;
            sw_present  = present_ff[i];
         end
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign scan_done  = (state_ff == ST_SCAN) && (issue_ff == CNT_END) && !chk_vld_ff;
   assign dst_en     = !((func_ff == FUNC_MISS) && (dst_ff == MAC_BCAST));
   assign ent_ok     = ram_rdata.valid && (ram_rdata.sw == sw_ff);
   assign do_learn   = (func_ff == FUNC_MISS) && (src_ff != MAC_BCAST) && !src_found_ff
                       && free_found_ff;

   // sequencer and next-state logic
   always_comb begin
      state_in       = state_ff;
      issue_in       = issue_ff;
      chk_vld_in     = 1'b0;
      chk_addr_in    = issue_ff[IDX_W-1:0];
      func_in        = func_ff;
      sw_in          = sw_ff;
      src_in         = src_ff;
      dst_in         = dst_ff;
      port_in        = port_ff;
      dst_found_in   = dst_found_ff;
      dst_idx_in     = dst_idx_ff;
      src_found_in   = src_found_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      res_fwd_in     = res_fwd_ff;
      res_flood_in   = res_flood_ff;
      res_port_in    = res_port_ff;
      res_learned_in = res_learned_ff;
      res_prio_in    = res_prio_ff;
      res_full_in    = res_full_ff;
      res_notab_in   = res_notab_ff;
      prio_in        = prio_ff;
      present_in     = present_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      ram_we         = 1'b0;
      ram_waddr      = issue_ff[IDX_W-1:0];
      ram_wdata      = '0;

      unique case (state_ff)
         // invalidate every entry after reset
         ST_CLEAR: begin
            ram_we = 1'b1;
            if (issue_ff == CNT_LAST) begin
               issue_in = '0;
               state_in = ST_IDLE;
            end else begin
               issue_in = issue_ff + CNT_W'(1);
            end
         end

         // take an event and settle the cases that need no table scan
         ST_IDLE: begin
            if (accept) begin
               func_in        = req_tuser;
               sw_in          = req_sw;
               src_in         = req_src;
               dst_in         = req_dst;
               port_in        = req_port;
               dst_found_in   = 1'b0;
               src_found_in   = 1'b0;
               free_found_in  = 1'b0;
               issue_in       = '0;
               res_fwd_in     = 1'b0;
               res_flood_in   = 1'b0;
               res_port_in    = '0;
               res_learned_in = 1'b0;
               res_prio_in    = '0;
               res_full_in    = 1'b0;
               res_notab_in   = 1'b0;
               state_in       = ST_DONE;
               case (req_tuser)
                  FUNC_MISS: begin
                     if (req_no_match) begin
                        res_fwd_in   = 1'b1;
                        res_flood_in = 1'b1;
                        if (sw_present) begin
                           state_in = ST_SCAN;
                        end else begin
                           res_notab_in = 1'b1;
                        end
                     end
                  end
                  FUNC_REMOVE: begin
                     if (sw_present) begin
                        state_in = ST_SCAN;
                     end else begin
                        res_notab_in = 1'b1;
                     end
                  end
                  FUNC_CONNECT: begin
                     if (!sw_slot_hit || sw_present) begin
                        res_notab_in = 1'b1;
                     end else begin
                        for (int i = 0; i < PRESENT_W; i++) begin
                           if (req_sw == SW_W'(i)) begin
                              present_in[i] = 1'b1;
                           end
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         // issue one read per cycle, check the entry read the cycle before
         ST_SCAN: begin
            if (issue_ff != CNT_END) begin
               chk_vld_in = 1'b1;
               issue_in   = issue_ff + CNT_W'(1);
            end
            if (chk_vld_ff) begin
               if (ent_ok && (ram_rdata.mac == dst_ff) && dst_en && !dst_found_ff) begin
                  dst_found_in = 1'b1;
                  dst_idx_in   = chk_addr_ff;
                  if (func_ff == FUNC_MISS) begin
                     res_flood_in = 1'b0;
                     res_port_in  = ram_rdata.port;
                  end
               end
               if (ent_ok && (ram_rdata.mac == src_ff)) begin
                  src_found_in = 1'b1;
               end
               if (!ram_rdata.valid && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = chk_addr_ff;
               end
            end
            if (scan_done) begin
               state_in = ST_WRITE;
            end
         end

         // learn the source or delete the expired entry
         ST_WRITE: begin
            state_in = ST_DONE;
            if (func_ff == FUNC_MISS) begin
               if (do_learn) begin
                  ram_we         = 1'b1;
                  ram_waddr      = free_idx_ff;
                  ram_wdata      = '{valid: 1'b1, sw: sw_ff, mac: src_ff, port: port_ff};
                  prio_in        = prio_ff + PRIO_W'(1);
                  res_learned_in = 1'b1;
                  res_prio_in    = prio_ff + PRIO_W'(1);
               end else if ((src_ff != MAC_BCAST) && !src_found_ff) begin
                  res_full_in = 1'b1;
               end
            end else if (dst_found_ff) begin
               ram_we    = 1'b1;
               ram_waddr = dst_idx_ff;
               ram_wdata = '{valid: 1'b0, sw: sw_ff, mac: dst_ff, port: port_ff};
            end
         end

         // hand the result to the output register once it is free
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'b000, res_notab_ff, res_full_ff, res_prio_ff,
                               res_learned_ff, res_port_ff, res_flood_ff, res_fwd_ff};
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state, control and payload registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         issue_ff     <= '0;
         chk_vld_ff   <= 1'b0;
         prio_ff      <= PRIO_RESET;
         present_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         chk_vld_ff   <= chk_vld_in;
         prio_ff      <= prio_in;
         present_ff   <= present_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      chk_addr_ff    <= chk_addr_in;
      func_ff        <= func_in;
      sw_ff          <= sw_in;
      src_ff         <= src_in;
      dst_ff         <= dst_in;
      port_ff        <= port_in;
      dst_found_ff   <= dst_found_in;
      dst_idx_ff     <= dst_idx_in;
      src_found_ff   <= src_found_in;
      free_found_ff  <= free_found_in;
      free_idx_ff    <= free_idx_in;
      res_fwd_ff     <= res_fwd_in;
      res_flood_ff   <= res_flood_in;
      res_port_ff    <= res_port_in;
      res_learned_ff <= res_learned_in;
      res_prio_ff    <= res_prio_in;
      res_full_ff    <= res_full_in;
      res_notab_ff   <= res_notab_in;
      rsp_data_ff    <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   // no event is taken while the table is being cleared
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_tready)
      else $error("event accepted during table clear");

   // a scan only ends after every entry was read
   a_scan_complete: assert property (@(posedge clock) disable iff (reset)
      scan_done |-> (issue_ff == CNT_END))
      else $error("table scan ended early");

   // the priority counter moves only when an entry is learned
   a_prio_on_learn: assert property (@(posedge clock) disable iff (reset)
      !((state_ff == ST_WRITE) && do_learn) |=> (prio_ff == $past(prio_ff)))
      else $error("priority counter moved without learning");

   // learning and table full never come together
   a_learn_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> !(res_learned_ff && res_full_ff))
      else $error("learned and table_full both set");
`endif

endmodule

FILE: bench/mac_learning_port_table_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// MAC learning port table - testbench
// Drives connect, packet-miss and flow-removed events into the table and
// checks every forwarding decision against a local model of the shared
// learning table, the per-switch connect flags and the priority counter.
// Directed events first, then random fill and drain phases that run the
// table full and empty it again, with random idle bursts on both channels.
// ---------------------------------------------------------------------------
module mac_learning_port_table_tb;
   import mlpt_pkg::*;

   localparam int TABLE_ENTRIES = DEF_TABLE_ENTRIES;
   localparam int NUM_SWITCHES  = DEF_NUM_SWITCHES;
   // event code the block answers with an all-zero decision
   localparam logic [1:0] FUNC_RESERVED = 2'd3;

   localparam int RANDOM_EVENTS = 1330;
   localparam int PHASE_EVENTS  = 150;
   localparam int QUIET_TAIL    = 150;
   localparam int MAC_POOL_SIZE = 16;
   localparam int POOL_IDX_W    = $clog2(MAC_POOL_SIZE);
   localparam int DRAIN_CYCLES  = TABLE_ENTRIES + 8;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int REPORT_MAX    = 10;

   typedef struct {
      logic [1:0]        func;
      logic [SW_W-1:0]   sw;
      logic              no_match;
      logic [PORT_W-1:0] port;
      logic [MAC_W-1:0]  src;
      logic [MAC_W-1:0]  dst;
   } table_event_type;

   // laid out as on rsp_tdata, forward_valid in bit 0
   typedef struct packed {
      logic              no_table;
      logic              table_full;
      logic [PRIO_W-1:0] flow_priority;
      logic              learned;
      logic [PORT_W-1:0] out_port;
      logic              flood;
      logic              forward_valid;
   } decision_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [1:0]            req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   mac_learning_port_table DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #4 clock = ~clock;

   // model of the learning table
   logic                    known_valid [TABLE_ENTRIES];
   logic [SW_W-1:0]         known_sw    [TABLE_ENTRIES];
   logic [MAC_W-1:0]        known_mac   [TABLE_ENTRIES];
   logic [PORT_W-1:0]       known_port  [TABLE_ENTRIES];
   logic [NUM_SWITCHES-1:0] sw_connected;
   logic [PRIO_W-1:0]       prio_count;

   table_event_type  pending_events [$];
   decision_type     pending_decisions [$];
   logic [MAC_W-1:0] mac_pool [MAC_POOL_SIZE];

   table_event_type cur_event;
   decision_type    seen_decision;
   decision_type    want_decision;
   int           idle_left       = 0;
   int           idle_pct        = 20;
   int           stall_left      = 0;
   int           stall_pct       = 20;
   int           accepted_events = 0;
   int           rsp_beats       = 0;
   int           mismatches      = 0;
   int           cycle_count     = 0;

   function automatic int find_learned(logic [SW_W-1:0] sw, logic [MAC_W-1:0] mac);
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (known_valid[i] && known_sw[i] == sw && known_mac[i] == mac) return i;
      end
      return -1;
   endfunction

   // decide forwarding for one event and update the table model
   function automatic decision_type forward_and_learn(table_event_type ev);
      decision_type d;
      int        hit;
      int        slot;
      d = '0;
      case (ev.func)
         FUNC_MISS: begin
            if (ev.no_match) begin
               d.forward_valid = 1'b1;
               d.flood         = 1'b1;
               if (!sw_connected[ev.sw]) begin
                  d.no_table = 1'b1;
               end else begin
                  // destination lookup comes before the source is learned
                  if (ev.dst != MAC_BCAST) begin
                     hit = find_learned(ev.sw, ev.dst);
                     if (hit >= 0) begin
                        d.flood    = 1'b0;
                        d.out_port = known_port[hit];
                     end
                  end
                  if (ev.src != MAC_BCAST && find_learned(ev.sw, ev.src) < 0) begin
                     slot = -1;
                     for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
                        if (!known_valid[i]) slot = i;
                     end
                     if (slot < 0) begin
                        d.table_full = 1'b1;
                     end else begin
                        known_valid[slot] = 1'b1;
                        known_sw[slot]    = ev.sw;
                        known_mac[slot]   = ev.src;
                        known_port[slot]  = ev.port;
                        prio_count        = prio_count + PRIO_W'(1);
                        d.learned         = 1'b1;
                        d.flow_priority   = prio_count;
                     end
                  end
               end
            end
         end
         FUNC_REMOVE: begin
            if (!sw_connected[ev.sw]) begin
               d.no_table = 1'b1;
            end else begin
               hit = find_learned(ev.sw, ev.dst);
               if (hit >= 0) known_valid[hit] = 1'b0;
            end
         end
         FUNC_CONNECT: begin
            if (sw_connected[ev.sw]) d.no_table = 1'b1;
            else sw_connected[ev.sw] = 1'b1;
         end
         default: ;
      endcase
      return d;
   endfunction

   function automatic int pick_idle_pct();
      case ($urandom_range(0, 2))
         0:       return 0;
         1:       return 15;
         default: return 45;
      endcase
   endfunction

   // mostly pool addresses so lookups hit, some broadcast, some fresh
   function automatic logic [MAC_W-1:0] pick_mac(int bcast_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < bcast_pct) return MAC_BCAST;
      if (roll < 90) return mac_pool[POOL_IDX_W'($urandom_range(0, MAC_POOL_SIZE - 1))];
      return MAC_W'({$urandom, $urandom});
   endfunction

   task automatic push_event(logic [1:0] func, logic [SW_W-1:0] sw, logic no_match,
                             logic [PORT_W-1:0] port, logic [MAC_W-1:0] src,
                             logic [MAC_W-1:0] dst);
      table_event_type ev;
      ev.func     = func;
      ev.sw       = sw;
      ev.no_match = no_match;
      ev.port     = port;
      ev.src      = src;
      ev.dst      = dst;
      pending_events.push_back(ev);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         // predict the beat taken at this edge
         if (req_tvalid && req_tready) begin
            pending_decisions.push_back(forward_and_learn(cur_event));
            accepted_events++;
            if (accepted_events % 100 == 0) idle_pct = pick_idle_pct();
         end
         // present the next beat once the current one is gone
         if (!req_tvalid || req_tready) begin
            if (idle_left > 0) begin
               idle_left--;
               req_tvalid <= 1'b0;
            end else if (pending_events.size() > 0) begin
               cur_event = pending_events.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= REQ_DATA_W'({cur_event.dst, cur_event.src, cur_event.port,
                                          cur_event.no_match, cur_event.sw});
               req_tuser  <= cur_event.func;
               if (pending_events.size() > QUIET_TAIL && $urandom_range(0, 99) < idle_pct)
                  idle_left = $urandom_range(1, 8);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen_decision = decision_type'(rsp_tdata[$bits(decision_type)-1:0]);
            rsp_beats++;
            if (rsp_beats % 100 == 0) stall_pct = pick_idle_pct();
            if (pending_decisions.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("tb: unexpected decision beat %h", rsp_tdata);
            end else begin
               want_decision = pending_decisions.pop_front();
               if (seen_decision !== want_decision) begin
                  mismatches++;
                  if (mismatches <= REPORT_MAX) begin
                     $display({"tb: beat %0d want fv=%0d fl=%0d port=%h lrn=%0d",
                               " prio=%h full=%0d nt=%0d"},
                              rsp_beats, want_decision.forward_valid, want_decision.flood,
                              want_decision.out_port, want_decision.learned,
                              want_decision.flow_priority, want_decision.table_full,
                              want_decision.no_table);
                     $display({"tb: beat %0d got  fv=%0d fl=%0d port=%h lrn=%0d",
                               " prio=%h full=%0d nt=%0d"},
                              rsp_beats, seen_decision.forward_valid, seen_decision.flood,
                              seen_decision.out_port, seen_decision.learned,
                              seen_decision.flow_priority, seen_decision.table_full,
                              seen_decision.no_table);
                  end
               end
            end
         end
         // stall in random bursts, none near the end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (pending_events.size() > QUIET_TAIL && $urandom_range(0, 99) < stall_pct)
               stall_left = $urandom_range(1, 8);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      logic [MAC_W-1:0] mac_a;
      logic [MAC_W-1:0] mac_b;
      logic [MAC_W-1:0] mac_c;
      logic [SW_W-1:0]  sw;
      logic             draining;
      int               roll;

      for (int i = 0; i < TABLE_ENTRIES; i++) known_valid[i] = 1'b0;
      sw_connected = '0;
      prio_count   = PRIO_RESET;
      for (int i = 0; i < MAC_POOL_SIZE; i++) mac_pool[i] = MAC_W'({$urandom, $urandom});
      mac_a = 48'h0200_5e00_00a1;
      mac_b = 48'hfeff_ffff_ffff;
      mac_c = 48'h8000_0000_0001;

      // directed: unconnected switches, connect rules, reserved code, lookups
      push_event(FUNC_MISS,     3'd0, 1'b1, 32'd5,        mac_a,     mac_b);
      push_event(FUNC_REMOVE,   3'd1, 1'b0, 32'd0,        mac_a,     mac_a);
      push_event(FUNC_CONNECT,  3'd0, 1'b0, 32'd0,        48'd0,     48'd0);
      push_event(FUNC_CONNECT,  3'd0, 1'b1, 32'hffffffff, MAC_BCAST, MAC_BCAST);
      push_event(FUNC_CONNECT,  3'd7, 1'b0, 32'd0,        48'd0,     48'd0);
      push_event(FUNC_RESERVED, 3'd0, 1'b1, 32'hffffffff, mac_a,     mac_a);
      push_event(FUNC_MISS,     3'd0, 1'b0, 32'd9,        mac_a,     mac_b);
      // unknown destination equal to source: flood, then learn
      push_event(FUNC_MISS,     3'd0, 1'b1, 32'hffffffff, mac_a,     mac_a);
      push_event(FUNC_MISS,     3'd0, 1'b1, 32'd0,        mac_b,     mac_a);
      // known source keeps its port
      push_event(FUNC_MISS,     3'd0, 1'b1, 32'd12345,    mac_a,     mac_b);
      push_event(FUNC_MISS,     3'd0, 1'b1, 32'd77,       MAC_BCAST, MAC_BCAST);
      push_event(FUNC_MISS,     3'd0, 1'b1, 32'h80000000, 48'd0,     48'd0);
      push_event(FUNC_MISS,     3'd0, 1'b1, 32'd3,        mac_a,     48'd0);
      // tables are kept apart per switch
      push_event(FUNC_MISS,     3'd7, 1'b1, 32'h5a5a5a5a, mac_a,     mac_a);
      push_event(FUNC_REMOVE,   3'd0, 1'b1, 32'd0,        mac_b,     mac_a);
      push_event(FUNC_REMOVE,   3'd0, 1'b0, 32'd0,        mac_b,     mac_c);
      // freed slot is reused for the next learn
      push_event(FUNC_MISS,     3'd0, 1'b1, 32'd44,       mac_c,     mac_a);
      push_event(FUNC_MISS,     3'd7, 1'b1, 32'd45,       mac_b,     mac_a);
      push_event(FUNC_MISS,     3'd0, 1'b1, 32'd46,       mac_b,     mac_c);
      push_event(FUNC_CONNECT,  3'd3, 1'b0, 32'd0,        48'd0,     48'd0);
      push_event(FUNC_MISS,     3'd3, 1'b1, 32'd47,       mac_c,     MAC_BCAST);

      // random: alternate phases that fill the table and drain it
      for (int n = 0; n < RANDOM_EVENTS; n++) begin
         draining = ((n / PHASE_EVENTS) % 2) == 1;
         roll     = $urandom_range(0, 99);
         sw       = SW_W'($urandom_range(0, NUM_SWITCHES - 1));
         if (roll < (draining ? 30 : 72))
            push_event(FUNC_MISS, sw, 1'b1, $urandom, pick_mac(5), pick_mac(10));
         else if (roll < (draining ? 88 : 84))
            push_event(FUNC_REMOVE, sw, 1'($urandom_range(0, 1)), $urandom, pick_mac(5),
                       pick_mac(2));
         else if (roll < (draining ? 91 : 88))
            push_event(FUNC_CONNECT, sw, 1'($urandom_range(0, 1)), $urandom, pick_mac(5),
                       pick_mac(5));
         else if (roll < 95)
            push_event(FUNC_MISS, sw, 1'b0, $urandom, pick_mac(5), pick_mac(10));
         else
            push_event(FUNC_RESERVED, sw, 1'($urandom_range(0, 1)), $urandom, pick_mac(5),
                       pick_mac(5));
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pending_events.size() > 0 || req_tvalid || pending_decisions.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && pending_decisions.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hdl/mlpt_pkg.sv
hdl/mlpt_ram.sv
hdl/mac_learning_port_table.sv
bench/mac_learning_port_table_tb.sv
